// File: rtl/mgt_pkg.sv
// Shared types and codes for the multicast group membership table.
package mgt_pkg;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_REPORT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_AGE    = 2'd2;
   localparam logic [1:0] FUNC_FLUSH  = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_DONE       = 3'd0;
   localparam logic [2:0] ST_MATCHED    = 3'd1;
   localparam logic [2:0] ST_CREATED    = 3'd2;
   localparam logic [2:0] ST_INVALID    = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_UNFILTERED = 3'd5;
   localparam logic [2:0] ST_NOGROUP    = 3'd6;

   // Command kinds decided by the front end.
   localparam logic [2:0] CMD_REPORT     = 3'd0;
   localparam logic [2:0] CMD_INVALID    = 3'd1;
   localparam logic [2:0] CMD_UNFILTERED = 3'd2;
   localparam logic [2:0] CMD_ALL_PORTS  = 3'd3;
   localparam logic [2:0] CMD_LOOKUP     = 3'd4;
   localparam logic [2:0] CMD_AGE        = 3'd5;
   localparam logic [2:0] CMD_FLUSH      = 3'd6;

   // Well-known addresses.
   localparam logic [31:0] ADDR_ALL_SYSTEMS = 32'hE000_0001;
   localparam logic [31:0] ADDR_ALL_ROUTERS = 32'hE000_0002;
   localparam logic [31:0] ADDR_BROADCAST   = 32'hFFFF_FFFF;
   localparam logic [3:0]  MCAST_PREFIX     = 4'hE;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
      logic [31:0] port_mask;
   } req_type;

   typedef struct packed {
      logic [31:0] out_mask;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [31:0] port_mask;
   } cmd_type;

endpackage

// File: rtl/mgt_front.sv
// Front end: decodes request words into commands and queues them for the table engine.
module mgt_front
   import mgt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    init_done,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd_new;
   logic       is_mcast;
   logic       push, pop;

   assign is_mcast = (req_data.address[31:28] == MCAST_PREFIX);

   always_comb begin
      cmd_new.address   = req_data.address;
      cmd_new.port_mask = req_data.port_mask;
      unique case (req_data.func)
         FUNC_REPORT: begin
            if (is_mcast && req_data.address != ADDR_BROADCAST) cmd_new.kind = CMD_REPORT;
            else cmd_new.kind = CMD_INVALID;
         end
         FUNC_LOOKUP: begin
            if (!is_mcast || req_data.address == ADDR_BROADCAST) begin
               cmd_new.kind = CMD_UNFILTERED;
            end else if (req_data.address == ADDR_ALL_SYSTEMS ||
                         req_data.address == ADDR_ALL_ROUTERS) begin
               cmd_new.kind = CMD_ALL_PORTS;
            end else begin
               cmd_new.kind = CMD_LOOKUP;
            end
         end
         FUNC_AGE:   cmd_new.kind = CMD_AGE;
         FUNC_FLUSH: cmd_new.kind = CMD_FLUSH;
         default:    cmd_new.kind = CMD_FLUSH;
      endcase
   end

   // No word is taken until the table has been cleared after reset.
   assign req_ready = (count_ff != 2'd2) && init_done;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: rtl/mgt_back.sv
// Back end: table memory, entry walker for report, lookup, aging and clearing, result register.
module mgt_back
   import mgt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int PORTS         = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    init_done,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [63:0] PORT_ALL64 =
      (PORTS >= 64) ? {64{1'b1}} : ((64'd1 << PORTS) - 64'd1);
   localparam logic [31:0] PORT_ALL32 = PORT_ALL64[31:0];

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   typedef struct packed {
      logic [31:0]      address;
      logic [PORTS-1:0] active;
      logic [PORTS-1:0] older;
      logic [PORTS-1:0] newer;
   } entry_type;

   entry_type mem_ff [TABLE_ENTRIES];
   entry_type rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          flush_ff, flush_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   entry_type     hit_entry_ff, hit_entry_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   cmd_type       cmd_ff, cmd_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             rsp_load;
   logic [63:0]      pm64;
   logic [PORTS-1:0] rep_mask;
   logic [63:0]      act64;
   logic [PORTS-1:0] aged_active;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_done = !(st_ff == S_CLEAR && !flush_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pm64        = 64'(cmd_ff.port_mask);
   assign rep_mask    = pm64[PORTS-1:0];
   assign act64       = 64'(hit_entry_ff.active);
   assign aged_active = rd_data_ff.older | rd_data_ff.newer;

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      rd_addr      = '0;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      cmd_ready    = 1'b0;
      rsp_load     = 1'b0;

      unique case (st_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IW-1:0];
            if (cnt_ff == CW'(TABLE_ENTRIES - 1)) begin
               res_in = '{out_mask: 32'd0, status: ST_DONE};
               st_in  = flush_ff ? S_DONE : S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in  = cmd_data;
               cnt_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               unique case (cmd_data.kind)
                  CMD_INVALID: begin
                     res_in = '{out_mask: 32'd0, status: ST_INVALID};
                     st_in  = S_DONE;
                  end
                  CMD_UNFILTERED: begin
                     res_in = '{out_mask: cmd_data.port_mask, status: ST_UNFILTERED};
                     st_in  = S_DONE;
                  end
                  CMD_ALL_PORTS: begin
                     res_in = '{out_mask: cmd_data.port_mask & PORT_ALL32,
                                status: ST_MATCHED};
                     st_in  = S_DONE;
                  end
                  CMD_FLUSH: begin
                     flush_in = 1'b1;
                     st_in    = S_CLEAR;
                  end
                  default: begin
                     st_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Reads are issued one entry a cycle; the read data comes back through a register.
            if (cnt_ff < CW'(TABLE_ENTRIES)) begin
               rd_addr    = cnt_ff[IW-1:0];
               rd_vld_in  = 1'b1;
               rd_last_in = (cnt_ff == CW'(TABLE_ENTRIES - 1));
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (!hit_ff && rd_data_ff.address == cmd_ff.address) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_entry_in = rd_data_ff;
               end
               if (!free_ff && rd_data_ff.address == 32'd0) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (cmd_ff.kind == CMD_AGE) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_idx_ff;
                  if (aged_active != '0) begin
                     wr_data.address = rd_data_ff.address;
                     wr_data.active  = aged_active;
                     wr_data.older   = rd_data_ff.newer;
                     wr_data.newer   = '0;
                  end
               end
               if (rd_last_ff) begin
                  st_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            res_in = '{out_mask: 32'd0, status: ST_DONE};
            if (cmd_ff.kind == CMD_REPORT) begin
               if (hit_ff) begin
                  wr_en           = 1'b1;
                  wr_addr         = hit_idx_ff;
                  wr_data.address = hit_entry_ff.address;
                  wr_data.active  = hit_entry_ff.active | rep_mask;
                  wr_data.older   = hit_entry_ff.older | rep_mask;
                  wr_data.newer   = hit_entry_ff.newer | rep_mask;
                  res_in.status   = ST_MATCHED;
               end else if (free_ff) begin
                  wr_en           = 1'b1;
                  wr_addr         = free_idx_ff;
                  wr_data.address = cmd_ff.address;
                  wr_data.active  = rep_mask;
                  wr_data.older   = rep_mask;
                  wr_data.newer   = rep_mask;
                  res_in.status   = ST_CREATED;
               end else begin
                  res_in.status = ST_FULL;
               end
            end else if (cmd_ff.kind == CMD_LOOKUP) begin
               if (hit_ff) begin
                  res_in = '{out_mask: cmd_ff.port_mask & act64[31:0], status: ST_MATCHED};
               end else begin
                  res_in.status = ST_NOGROUP;
               end
            end
            st_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               flush_in = 1'b0;
               st_in    = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_idx_in    = rd_addr;
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_CLEAR;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
      cmd_ff       <= cmd_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   a_last_read_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SCAN && rd_vld_ff && rd_last_ff) |=> (st_ff == S_FINISH))
      else $error("walk did not finish after the last entry was read");

   a_hit_address_matches: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_FINISH && hit_ff) |-> (hit_entry_ff.address == cmd_ff.address))
      else $error("captured entry does not hold the requested group");

   a_no_write_when_quiet: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (st_ff != S_IDLE && st_ff != S_DONE))
      else $error("table written outside a walk, finish or clearing pass");

   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DONE && out_free) |=> (rsp_valid_ff && st_ff == S_IDLE))
      else $error("finished result did not reach the output register");

endmodule

// File: rtl/multicast_group_membership_table_unit.sv
// Top level of the multicast group membership table: front end, command queue and table engine.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type)
//
// Report, group lookup and end of window walk every entry through the single read port
// of the table memory. Other reports and lookups are answered without a walk; flush
// sweeps the memory one entry a cycle. After reset a clearing pass over every entry
// runs before req_ready rises. A two-word command queue takes new words while the
// engine or a stalled result register is busy.
module multicast_group_membership_table_unit
   import mgt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int PORTS         = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;
   logic    init_done;

   mgt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .init_done (init_done),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   mgt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PORTS         (PORTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/multicast_group_membership_table_unit_tb.sv
// Testbench for the multicast group membership table: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module multicast_group_membership_table_unit_tb;
   import mgt_pkg::*;

   localparam int TABLE_ENTRIES = 32;
   localparam int PORTS         = 32;
   localparam int POOL_SIZE     = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PRINT_LIMIT   = 200;
   localparam logic [31:0] PORTS_ALL = (PORTS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PORTS) - 32'd1);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predicted table contents.
   logic [31:0] grp_addr   [TABLE_ENTRIES];
   logic [31:0] grp_active [TABLE_ENTRIES];
   logic [31:0] grp_older  [TABLE_ENTRIES];
   logic [31:0] grp_newer  [TABLE_ENTRIES];

   rsp_type     pending_rsp[$];
   logic [31:0] group_pool [POOL_SIZE];
   int          error_count  = 0;
   int          cycle_count  = 0;
   int          hold_request = 0;
   int          stall_left   = 0;
   int          run_left     = 0;
   int          pick         = 0;
   bit          sender_eager = 1'b0;

   multicast_group_membership_table_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PORTS        (PORTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic int find_group(input logic [31:0] address);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (grp_addr[i] == address) return i;
      return -1;
   endfunction

   function automatic void clear_group(input int slot, input logic [31:0] address);
      grp_addr[slot]   = address;
      grp_active[slot] = '0;
      grp_older[slot]  = '0;
      grp_newer[slot]  = '0;
   endfunction

   // Applies one word to the predicted table and returns the result it should produce.
   function automatic rsp_type predict_group_word(input req_type w);
      rsp_type     r;
      int          slot;
      logic        is_mcast;
      logic [31:0] m;
      r.out_mask = '0;
      r.status   = ST_DONE;
      is_mcast   = (w.address[31:28] == MCAST_PREFIX);
      case (w.func)
         FUNC_REPORT: begin
            if (!is_mcast || w.address == ADDR_BROADCAST) begin
               r.status = ST_INVALID;
            end else begin
               slot     = find_group(w.address);
               r.status = ST_MATCHED;
               if (slot < 0) begin
                  slot = find_group('0);
                  if (slot >= 0) begin
                     clear_group(slot, w.address);
                     r.status = ST_CREATED;
                  end else begin
                     r.status = ST_FULL;
                  end
               end
               if (slot >= 0) begin
                  m = w.port_mask & PORTS_ALL;
                  grp_active[slot] |= m;
                  grp_older[slot]  |= m;
                  grp_newer[slot]  |= m;
               end
            end
         end
         FUNC_LOOKUP: begin
            if (!is_mcast || w.address == ADDR_BROADCAST) begin
               r.out_mask = w.port_mask;
               r.status   = ST_UNFILTERED;
            end else if (w.address == ADDR_ALL_SYSTEMS || w.address == ADDR_ALL_ROUTERS) begin
               r.out_mask = w.port_mask & PORTS_ALL;
               r.status   = ST_MATCHED;
            end else begin
               slot = find_group(w.address);
               if (slot >= 0) begin
                  r.out_mask = w.port_mask & grp_active[slot];
                  r.status   = ST_MATCHED;
               end else begin
                  r.status = ST_NOGROUP;
               end
            end
         end
         FUNC_AGE: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               grp_active[i] = grp_older[i] | grp_newer[i];
               grp_older[i]  = grp_newer[i];
               grp_newer[i]  = '0;
               if (grp_active[i] == '0) clear_group(i, '0);
            end
         end
         default: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) clear_group(i, '0);
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called at a falling edge; returns at a falling edge with valid still high when no gap follows.
   task automatic send_word(input req_type w);
      int gap;
      req_data  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_group_word(w));
      @(negedge clock);
      gap = sender_eager ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_fields(input logic [1:0] func, input logic [31:0] address,
                              input logic [31:0] port_mask);
      req_type w;
      w.func      = func;
      w.address   = address;
      w.port_mask = port_mask;
      send_word(w);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type random_word(input int age_pct);
      req_type w;
      int      r;
      r = $urandom_range(0, 99);
      if (r == 0) w.func = FUNC_FLUSH;
      else if (r <= age_pct) w.func = FUNC_AGE;
      else if ($urandom_range(0, 1) == 0) w.func = FUNC_REPORT;
      else w.func = FUNC_LOOKUP;
      r = $urandom_range(0, 99);
      if (r < 55) w.address = group_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 59) w.address = ADDR_ALL_SYSTEMS;
      else if (r < 63) w.address = ADDR_ALL_ROUTERS;
      else if (r < 68) w.address = ADDR_BROADCAST;
      else if (r < 78) w.address = {MCAST_PREFIX, 28'($urandom())};
      else w.address = $urandom();
      r = $urandom_range(0, 99);
      if (r < 10) w.port_mask = '0;
      else if (r < 20) w.port_mask = '1;
      else if (r < 30) w.port_mask = 32'd1 << $urandom_range(0, 31);
      else w.port_mask = $urandom();
      return w;
   endfunction

   task automatic test_directed_cases();
      send_fields(FUNC_LOOKUP, 32'hE123_4567, 32'hFFFF_FFFF);
      send_fields(FUNC_LOOKUP, ADDR_BROADCAST, 32'hDEAD_BEEF);
      send_fields(FUNC_LOOKUP, 32'h0A00_0001, 32'h1234_5678);
      send_fields(FUNC_LOOKUP, 32'hF000_0000, 32'hFFFF_FFFF);
      send_fields(FUNC_LOOKUP, 32'hDFFF_FFFF, 32'h0000_0000);
      send_fields(FUNC_LOOKUP, ADDR_ALL_SYSTEMS, 32'hFFFF_FFFF);
      send_fields(FUNC_LOOKUP, ADDR_ALL_ROUTERS, 32'h5A5A_A5A5);
      send_fields(FUNC_REPORT, ADDR_BROADCAST, 32'hFFFF_FFFF);
      send_fields(FUNC_REPORT, 32'h0000_0000, 32'h0000_0001);
      send_fields(FUNC_REPORT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_fields(FUNC_REPORT, 32'hE000_0000, 32'h0000_0001);
      send_fields(FUNC_REPORT, 32'hEFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(FUNC_REPORT, 32'hE000_0000, 32'h8000_0000);
      // A report with an empty mask still creates the group; aging frees it later.
      send_fields(FUNC_REPORT, ADDR_ALL_SYSTEMS, 32'h0000_0000);
      send_fields(FUNC_LOOKUP, 32'hE000_0000, 32'hFFFF_FFFF);
      send_fields(FUNC_LOOKUP, 32'hEFFF_FFFF, 32'h1234_5678);
      send_fields(FUNC_AGE, 32'h0000_0000, 32'h0000_0000);
      send_fields(FUNC_LOOKUP, 32'hE000_0000, 32'h8000_0001);
      send_fields(FUNC_AGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(FUNC_AGE, 32'h1234_5678, 32'h9ABC_DEF0);
      send_fields(FUNC_LOOKUP, 32'hE000_0000, 32'hFFFF_FFFF);
      send_fields(FUNC_REPORT, ADDR_ALL_ROUTERS, 32'hAAAA_5555);
      send_fields(FUNC_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(FUNC_LOOKUP, ADDR_ALL_ROUTERS, 32'h0F0F_F0F0);
      send_fields(FUNC_LOOKUP, 32'hEFFF_FFFF, 32'hFFFF_FFFF);
      wait_drain();
   endtask

   // Fills every slot, overflows the table, then ages groups out and refills freed slots.
   task automatic test_table_fill_and_aging();
      logic [31:0] fresh [TABLE_ENTRIES + 8];
      foreach (fresh[i]) fresh[i] = {MCAST_PREFIX, 28'($urandom())};
      send_fields(FUNC_FLUSH, $urandom(), $urandom());
      foreach (fresh[i])
         send_fields(FUNC_REPORT, fresh[i], ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom());
      foreach (fresh[i]) send_fields(FUNC_LOOKUP, fresh[i], $urandom());
      send_fields(FUNC_AGE, $urandom(), $urandom());
      for (int i = 0; i < 12; i++)
         send_fields(FUNC_REPORT, fresh[$urandom_range(0, TABLE_ENTRIES + 7)], $urandom());
      send_fields(FUNC_AGE, $urandom(), $urandom());
      send_fields(FUNC_AGE, $urandom(), $urandom());
      foreach (fresh[i]) send_fields(FUNC_LOOKUP, fresh[i], 32'hFFFF_FFFF);
      for (int i = 0; i < 20; i++)
         send_fields(FUNC_REPORT, fresh[$urandom_range(0, TABLE_ENTRIES + 7)], $urandom());
      wait_drain();
   endtask

   task automatic test_random_traffic(input int count, input int age_pct);
      for (int i = 0; i < count; i++) send_word(random_word(age_pct));
      wait_drain();
   endtask

   // The receiver holds off long enough for the command queue to fill and stall the input.
   task automatic test_output_backpressure();
      hold_request = 400;
      sender_eager = 1'b1;
      for (int i = 0; i < 40; i++) send_word(random_word(5));
      sender_eager = 1'b0;
      wait_drain();
   endtask

   task automatic test_drain_pauses();
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 5; i++) send_word(random_word(10));
         wait_drain();
      end
   endtask

   // Receiver: runs of ready, short stalls, a few long ones, and a requested hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
            run_left     = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) run_left = $urandom_range(1, 4);
            else if (pick < 60) run_left = $urandom_range(20, 80);
            else if (pick < 92) stall_left = $urandom_range(1, 3);
            else stall_left = $urandom_range(10, 40);
         end
         if (stall_left != 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            run_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing pending, out_mask", rsp_data.out_mask, '0);
         end else begin
            if (rsp_data.out_mask !== pending_rsp[0].out_mask)
               report_mismatch("out_mask", rsp_data.out_mask, pending_rsp[0].out_mask);
            if (rsp_data.status !== pending_rsp[0].status)
               report_mismatch("status", 32'(rsp_data.status), 32'(pending_rsp[0].status));
            void'(pending_rsp.pop_front());
         end
      end
   end

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) clear_group(i, '0);
      foreach (group_pool[i]) group_pool[i] = {MCAST_PREFIX, 28'($urandom())};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_table_fill_and_aging();
      test_random_traffic(700, 3);
      test_output_backpressure();
      test_random_traffic(400, 15);
      test_drain_pauses();

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/mgt_pkg.sv
rtl/mgt_front.sv
rtl/mgt_back.sv
rtl/multicast_group_membership_table_unit.sv
test/multicast_group_membership_table_unit_tb.sv
